// File: rtl/mi3_pkg.sv
// Package for the 3x3 matrix inverse core.
// Holds default widths and the cofactor operand index tables. No dependencies.
`default_nettype none
package mi3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_ELEM         = 9;

    // Pipeline depth of the cofactor / determinant front end.
    localparam int FRONT_STAGES = 5;

    // Cofactor k (row-major) = m[CF_A]*m[CF_B] - m[CF_C]*m[CF_D],
    // element index = row*3 + col.
    localparam int CF_A [N_ELEM] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
    localparam int CF_B [N_ELEM] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
    localparam int CF_C [N_ELEM] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
    localparam int CF_D [N_ELEM] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

    // Determinant expands along row 0 against cofactors 00, 10, 20.
    localparam int DET_COF [3] = '{0, 3, 6};

endpackage
`default_nettype wire

// File: rtl/mi3_in_if.sv
// Input channel: one 3x3 matrix per transaction, valid/ready handshake.
// Depends on mi3_pkg.
`default_nettype none
interface mi3_in_if
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] elem_r0c0;
    logic signed [DATA_WIDTH-1:0] elem_r0c1;
    logic signed [DATA_WIDTH-1:0] elem_r0c2;
    logic signed [DATA_WIDTH-1:0] elem_r1c0;
    logic signed [DATA_WIDTH-1:0] elem_r1c1;
    logic signed [DATA_WIDTH-1:0] elem_r1c2;
    logic signed [DATA_WIDTH-1:0] elem_r2c0;
    logic signed [DATA_WIDTH-1:0] elem_r2c1;
    logic signed [DATA_WIDTH-1:0] elem_r2c2;

    modport source (
        output valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
               elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2,
        input  ready
    );
    modport sink (
        input  valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
               elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/mi3_out_if.sv
// Output channel: inverse matrix plus status flags, valid/ready handshake.
// Depends on mi3_pkg.
`default_nettype none
interface mi3_out_if
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] inv_r0c0;
    logic signed [DATA_WIDTH-1:0] inv_r0c1;
    logic signed [DATA_WIDTH-1:0] inv_r0c2;
    logic signed [DATA_WIDTH-1:0] inv_r1c0;
    logic signed [DATA_WIDTH-1:0] inv_r1c1;
    logic signed [DATA_WIDTH-1:0] inv_r1c2;
    logic signed [DATA_WIDTH-1:0] inv_r2c0;
    logic signed [DATA_WIDTH-1:0] inv_r2c1;
    logic signed [DATA_WIDTH-1:0] inv_r2c2;
    logic                         singular;
    logic                         saturated;

    modport source (
        output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
               inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
        input  ready
    );
    modport sink (
        input  valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
               inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/mi3_front.sv
// Front end: 2x2 cofactor products, cofactors, and the row-0 determinant.
// Five register stages, all advancing on i_en. Depends on mi3_pkg.
`default_nettype none
module mi3_front
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CW         = 2 * DATA_WIDTH + 1,
    parameter int DETW       = 3 * DATA_WIDTH + 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [DATA_WIDTH-1:0] i_m   [N_ELEM],
    output logic signed [CW-1:0]              o_cof [N_ELEM],
    output logic signed [DETW-1:0]            o_det
);
    localparam int DW = DATA_WIDTH;
    localparam int PW = DW + CW;    // m * cofactor

    logic signed [2*DW-1:0] r_pa   [N_ELEM];
    logic signed [2*DW-1:0] r_pc   [N_ELEM];
    logic signed [DW-1:0]   r_row1 [3];
    logic signed [CW-1:0]   r_cof2 [N_ELEM];
    logic signed [DW-1:0]   r_row2 [3];
    logic signed [2*DW:0]   r_plo  [3];
    logic signed [2*DW:0]   r_phi  [3];
    logic signed [CW-1:0]   r_cof3 [N_ELEM];
    logic signed [PW-1:0]   r_pj   [3];
    logic signed [CW-1:0]   r_cof4 [N_ELEM];
    logic signed [CW-1:0]   r_cof5 [N_ELEM];
    logic signed [DETW-1:0] r_det;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_pa[i] <= i_m[CF_A[i]] * i_m[CF_B[i]];
                r_pc[i] <= i_m[CF_C[i]] * i_m[CF_D[i]];
                r_cof2[i] <= CW'(r_pa[i]) - CW'(r_pc[i]);
                r_cof3[i] <= r_cof2[i];
                r_cof4[i] <= r_cof3[i];
                r_cof5[i] <= r_cof4[i];
            end
            for (int j = 0; j < 3; j++) begin
                r_row1[j] <= i_m[j];
                r_row2[j] <= r_row1[j];
                // cofactor split: unsigned low word, signed high part
                r_plo[j] <= r_row2[j] * $signed({1'b0, r_cof2[DET_COF[j]][DW-1:0]});
                r_phi[j] <= r_row2[j] * $signed(r_cof2[DET_COF[j]][CW-1:DW]);
                r_pj[j]  <= (PW'(r_phi[j]) <<< DW) + PW'(r_plo[j]);
            end
            r_det <= DETW'(r_pj[0]) + DETW'(r_pj[1]) + DETW'(r_pj[2]);
        end
    end

    assign o_cof = r_cof5;
    assign o_det = r_det;

endmodule
`default_nettype wire

// File: rtl/mi3_div_lane.sv
// One division lane: cofactor * 2^(2F) / det, truncated toward zero and
// saturated. Restoring divider, one quotient bit per stage. Depends on mi3_pkg.
`default_nettype none
module mi3_div_lane
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int CW         = 2 * DATA_WIDTH + 1,
    parameter int DETW       = 3 * DATA_WIDTH + 3
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic signed [CW-1:0]   i_cof,
    input  wire logic signed [DETW-1:0] i_det,
    output logic [DATA_WIDTH-1:0]       o_quot,
    output logic                        o_sat,
    output logic                        o_zero
);
    localparam int DW = DATA_WIDTH;
    localparam int AW = CW + 2 * FRAC_BITS;
    localparam int SW = DETW + DW;
    localparam int RW = (AW > SW) ? AW : SW;
    localparam int NS = DW + 1;     // steps: overflow bit, then DW quotient bits

    logic [CW-1:0]   w_cu;
    logic [CW-1:0]   w_cmag;
    logic [DETW-1:0] w_du;
    logic [DETW-1:0] w_dmag;

    logic [RW-1:0]   r_rem  [0:NS-1];
    logic [DETW-1:0] r_d    [0:NS-1];
    logic [DW-1:0]   r_q    [0:NS];
    logic            r_hi   [0:NS];
    logic            r_neg  [0:NS];
    logic            r_zero [0:NS];

    assign w_cu   = i_cof;
    assign w_du   = i_det;
    assign w_cmag = w_cu[CW-1] ? (~w_cu + CW'(1)) : w_cu;
    assign w_dmag = w_du[DETW-1] ? (~w_du + DETW'(1)) : w_du;

    // operand prep: magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RW'({w_cmag, {(2 * FRAC_BITS){1'b0}}});
            r_d[0]    <= w_dmag;
            r_q[0]    <= '0;
            r_hi[0]   <= 1'b0;
            r_neg[0]  <= w_cu[CW-1] ^ w_du[DETW-1];
            r_zero[0] <= (w_du == '0);
        end
    end

    for (genvar s = 1; s <= NS; s++) begin : g_step
        localparam int K = NS - s;  // quotient bit weight of this step
        logic [RW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = RW'(r_d[s-1]) << K;
        assign w_ge = (r_rem[s-1] >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s]    <= r_q[s-1] | (DW'(w_ge) << K);
                r_hi[s]   <= r_hi[s-1] | ((K == DW) & w_ge);
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
            end
        end

        if (s < NS) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? (r_rem[s-1] - w_sh) : r_rem[s-1];
                    r_d[s]   <= r_d[s-1];
                end
            end
        end
    end

    // saturate and apply sign
    logic [DW-1:0] w_half;
    logic [DW-1:0] w_lim;
    logic          w_sat;
    logic [DW-1:0] w_mag;

    assign w_half = {1'b1, {(DW - 1){1'b0}}};
    assign w_lim  = r_neg[NS] ? w_half : ~w_half;
    assign w_sat  = r_hi[NS] | (r_neg[NS] ? (r_q[NS] > w_half) : r_q[NS][DW-1]);
    assign w_mag  = w_sat ? w_lim : r_q[NS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[NS]) begin
                o_quot <= '0;
                o_sat  <= 1'b0;
            end else begin
                o_quot <= r_neg[NS] ? (~w_mag + DW'(1)) : w_mag;
                o_sat  <= w_sat;
            end
            o_zero <= r_zero[NS];
        end
    end

endmodule
`default_nettype wire

// File: rtl/mi3_merge.sv
// Merge stage: collects the nine lane results into the output register and
// folds the per-lane flags. Depends on mi3_pkg.
`default_nettype none
module mi3_merge
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [DATA_WIDTH-1:0] i_quot [N_ELEM],
    input  wire logic                  i_sat  [N_ELEM],
    input  wire logic                  i_zero,
    output logic [DATA_WIDTH-1:0]      o_inv  [N_ELEM],
    output logic                       o_singular,
    output logic                       o_saturated
);
    logic w_any_sat;

    always_comb begin
        w_any_sat = 1'b0;
        for (int i = 0; i < N_ELEM; i++) begin
            w_any_sat = w_any_sat | i_sat[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_inv       <= i_quot;
            o_singular  <= i_zero;
            o_saturated <= w_any_sat & ~i_zero;
        end
    end

endmodule
`default_nettype wire

// File: rtl/matrix_inverse_3x3_core.sv
// 3x3 matrix inverse by the adjugate method, signed fixed point.
// Pipeline: 5 front-end stages, DATA_WIDTH+3 divider stages (operand prep, one quotient
// bit per step stage, sign/saturate output), 1 merge/output register.
// Throughput: one matrix per cycle unless stalled; nine divider lanes, fully pipelined.
// Reset (i_rst_n, synchronous, active low) clears only the valid line; the
// pipeline stalls as a whole when the output transaction is held off.
`default_nettype none
module matrix_inverse_3x3_core
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mi3_in_if.sink     i_in,
    mi3_out_if.source  o_out
);
    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;        // cofactor width
    localparam int DETW = 3 * DW + 3;        // determinant width
    localparam int LAT  = FRONT_STAGES + DW + 3 + 1;

    // Pipeline enable: everything moves unless the output holds a
    // transaction the sink has not taken yet.
    logic w_en;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign w_en       = ~r_vld[LAT-1] | o_out.ready;
    assign i_in.ready = w_en;
    assign n_vld      = {r_vld[LAT-2:0], i_in.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // Gather the matrix in row-major order.
    logic signed [DW-1:0] w_m [N_ELEM];
    assign w_m[0] = i_in.elem_r0c0;
    assign w_m[1] = i_in.elem_r0c1;
    assign w_m[2] = i_in.elem_r0c2;
    assign w_m[3] = i_in.elem_r1c0;
    assign w_m[4] = i_in.elem_r1c1;
    assign w_m[5] = i_in.elem_r1c2;
    assign w_m[6] = i_in.elem_r2c0;
    assign w_m[7] = i_in.elem_r2c1;
    assign w_m[8] = i_in.elem_r2c2;

    // Cofactors and determinant.
    logic signed [CW-1:0]   w_cof [N_ELEM];
    logic signed [DETW-1:0] w_det;

    mi3_front #(
        .DATA_WIDTH (DW),
        .CW         (CW),
        .DETW       (DETW)
    ) u_front (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_m   (w_m),
        .o_cof (w_cof),
        .o_det (w_det)
    );

    // Nine divider lanes, one per inverse element.
    logic [DW-1:0] w_quot [N_ELEM];
    logic          w_sat  [N_ELEM];
    logic          w_zero [N_ELEM];

    for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
        mi3_div_lane #(
            .DATA_WIDTH (DW),
            .FRAC_BITS  (FRAC_BITS),
            .CW         (CW),
            .DETW       (DETW)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cof  (w_cof[i]),
            .i_det  (w_det),
            .o_quot (w_quot[i]),
            .o_sat  (w_sat[i]),
            .o_zero (w_zero[i])
        );
    end

    // Output register.
    logic [DW-1:0] w_inv [N_ELEM];
    logic          w_singular;
    logic          w_saturated;

    mi3_merge #(
        .DATA_WIDTH (DW)
    ) u_merge (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_quot      (w_quot),
        .i_sat       (w_sat),
        .i_zero      (w_zero[0] & w_zero[N_ELEM-1]),
        .o_inv       (w_inv),
        .o_singular  (w_singular),
        .o_saturated (w_saturated)
    );

    assign o_out.valid     = r_vld[LAT-1];
    assign o_out.inv_r0c0  = w_inv[0];
    assign o_out.inv_r0c1  = w_inv[1];
    assign o_out.inv_r0c2  = w_inv[2];
    assign o_out.inv_r1c0  = w_inv[3];
    assign o_out.inv_r1c1  = w_inv[4];
    assign o_out.inv_r1c2  = w_inv[5];
    assign o_out.inv_r2c0  = w_inv[6];
    assign o_out.inv_r2c1  = w_inv[7];
    assign o_out.inv_r2c2  = w_inv[8];
    assign o_out.singular  = w_singular;
    assign o_out.saturated = w_saturated;

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for matrix_inverse_3x3_core: random and directed 3x3 Q16.16 matrices.
// Depends on mi3_pkg, mi3_in_if, mi3_out_if and the core RTL.
`timescale 1ns / 100ps
module tb;
    import mi3_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [DW-1:0] elem_t;
    typedef struct {
        elem_t m [9];
    } matrix_t;
    typedef struct {
        elem_t inv [9];
        logic  singular;
        logic  saturated;
    } inverse_t;

    logic i_clk;
    logic i_rst_n;

    mi3_in_if  #(.DATA_WIDTH(DW)) in_ch ();
    mi3_out_if #(.DATA_WIDTH(DW)) out_ch ();

    matrix_inverse_3x3_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Inverse by adjugate in exact signed arithmetic; 200 bits is plenty for
    // cofactor * 2^32 against a 99-bit determinant.
    function automatic inverse_t predict_inverse(matrix_t a);
        logic signed [199:0] w [9];
        logic signed [199:0] cof [9];
        logic signed [199:0] det, num, q;
        logic signed [199:0] hi, lo;
        inverse_t r;
        hi = (200'sd1 <<< (DW - 1)) - 1;
        lo = -(200'sd1 <<< (DW - 1));
        for (int i = 0; i < 9; i++) w[i] = a.m[i];
        cof[0] = w[4] * w[8] - w[7] * w[5];
        cof[1] = w[2] * w[7] - w[1] * w[8];
        cof[2] = w[1] * w[5] - w[2] * w[4];
        cof[3] = w[5] * w[6] - w[3] * w[8];
        cof[4] = w[0] * w[8] - w[2] * w[6];
        cof[5] = w[3] * w[2] - w[0] * w[5];
        cof[6] = w[3] * w[7] - w[6] * w[4];
        cof[7] = w[6] * w[1] - w[0] * w[7];
        cof[8] = w[0] * w[4] - w[3] * w[1];
        det = w[0] * cof[0] + w[1] * cof[3] + w[2] * cof[6];
        r.singular = (det == 0);
        r.saturated = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (r.singular) begin
                r.inv[i] = '0;
            end else begin
                num = cof[i] <<< (2 * FB);
                q = num / det;  // SV signed division truncates toward zero
                if (q > hi) begin
                    q = hi;
                    r.saturated = 1'b1;
                end else if (q < lo) begin
                    q = lo;
                    r.saturated = 1'b1;
                end
                r.inv[i] = q[DW-1:0];
            end
        end
        return r;
    endfunction

    matrix_t  pending_matrices [$];
    inverse_t expected_inverses [$];
    int  send_idle_pct, recv_idle_pct;
    int  mismatches;
    int  cycles;
    bit  stimulus_done;

    // Driver: offers the head of the pending queue; a new item may replace an accepted
    // one within the same assignment, but valid is also dropped at random (send_idle_pct).
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) void'(pending_matrices.pop_front());
            if (pending_matrices.size() > (in_ch.valid ? 0 : 0) &&
                $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid     <= 1'b1;
                in_ch.elem_r0c0 <= pending_matrices[0].m[0];
                in_ch.elem_r0c1 <= pending_matrices[0].m[1];
                in_ch.elem_r0c2 <= pending_matrices[0].m[2];
                in_ch.elem_r1c0 <= pending_matrices[0].m[3];
                in_ch.elem_r1c1 <= pending_matrices[0].m[4];
                in_ch.elem_r1c2 <= pending_matrices[0].m[5];
                in_ch.elem_r2c0 <= pending_matrices[0].m[6];
                in_ch.elem_r2c1 <= pending_matrices[0].m[7];
                in_ch.elem_r2c2 <= pending_matrices[0].m[8];
                expected_inverses.push_back(predict_inverse(pending_matrices[0]));
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compares every output transaction with the oldest prediction.
    always @(posedge i_clk) begin
        inverse_t got, want;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.inv = '{out_ch.inv_r0c0, out_ch.inv_r0c1, out_ch.inv_r0c2,
                            out_ch.inv_r1c0, out_ch.inv_r1c1, out_ch.inv_r1c2,
                            out_ch.inv_r2c0, out_ch.inv_r2c1, out_ch.inv_r2c2};
                got.singular  = out_ch.singular;
                got.saturated = out_ch.saturated;
                if (expected_inverses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected output transaction");
                end else begin
                    want = expected_inverses.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (got.inv[i] !== want.inv[i]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("inv[%0d] exp %h got %h", i, want.inv[i], got.inv[i]);
                        end
                    end
                    if (got.singular !== want.singular || got.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("flags sing/sat exp %b%b got %b%b", want.singular,
                                     want.saturated, got.singular, got.saturated);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic elem_t random_elem(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(131071)) - 65536;     // around +-1.0
            2: return $signed($urandom_range(511)) - 256;          // tiny values
            default: return (($urandom_range(1) != 0) ? 32'sh7fffffff : 32'sh80000000)
                            ^ elem_t'($urandom_range(3));
        endcase
    endfunction

    task automatic queue_matrix(matrix_t a);
        pending_matrices.push_back(a);
    endtask

    initial begin
        matrix_t a;
        elem_t one;
        one = elem_t'(1) <<< FB;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.elem_r0c0 = '0; in_ch.elem_r0c1 = '0; in_ch.elem_r0c2 = '0;
        in_ch.elem_r1c0 = '0; in_ch.elem_r1c1 = '0; in_ch.elem_r1c2 = '0;
        in_ch.elem_r2c0 = '0; in_ch.elem_r2c1 = '0; in_ch.elem_r2c2 = '0;
        out_ch.ready = 1'b0;
        cycles = 0;
        mismatches = 0;
        stimulus_done = 0;
        send_idle_pct = 22;
        recv_idle_pct = 52;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identity, diagonal, zero, singular, all extremes, tiny det, permutation, mixed.
        a.m = '{one, 0, 0, 0, one, 0, 0, 0, one};               queue_matrix(a);
        a.m = '{2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2};  queue_matrix(a);
        a.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                     queue_matrix(a);
        a.m = '{one, 2 * one, 3 * one, 2 * one, 4 * one, 6 * one, 1, 2, 3};
        queue_matrix(a);
        for (int i = 0; i < 9; i++) a.m[i] = 32'sh7fffffff;     queue_matrix(a);
        for (int i = 0; i < 9; i++) a.m[i] = 32'sh80000000;     queue_matrix(a);
        a.m = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
        queue_matrix(a);
        a.m = '{32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff};
        queue_matrix(a);
        a.m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                     queue_matrix(a);
        a.m = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};                   queue_matrix(a);
        a.m = '{0, one, 0, one, 0, 0, 0, 0, -one};              queue_matrix(a);
        a.m = '{-1, -1, -1, -1, 2, 3, 5, -7, 11};               queue_matrix(a);
        a.m = '{32'sh55555555, 32'shaaaaaaaa, 1, 3, 32'sh55555555, 32'shaaaaaaaa,
                32'shaaaaaaaa, 7, 32'sh55555555};               queue_matrix(a);

        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < 150; n++) begin
                int mode;
                mode = $urandom_range(3);
                for (int i = 0; i < 9; i++) a.m[i] = random_elem(mode);
                if ($urandom_range(9) == 0) begin
                    // make row 2 a copy of row 0 for a singular matrix
                    a.m[6] = a.m[0]; a.m[7] = a.m[1]; a.m[8] = a.m[2];
                end
                queue_matrix(a);
            end
            while (pending_matrices.size() != 0) @(posedge i_clk);
            if (phase == 0) begin
                send_idle_pct = 52;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        stimulus_done = 1;
    end

    // End of run: drain, allow latency slack, then decide.
    initial begin
        wait (stimulus_done);
        while (expected_inverses.size() != 0 && cycles < CYCLE_LIMIT) @(posedge i_clk);
        repeat (2 * DW + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_inverses.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end
endmodule
